/* hw/rtl/sri_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sri_pkg;

  // fixed field widths of the two channels
  localparam int ROW_IDX_W = 8;
  localparam int COL_IDX_W = 16;
  localparam int VALUE_W   = 64;
  localparam int STATUS_W  = 2;
  localparam int OUT_POS_W = 5;

  // defaults for the top level parameters
  localparam int DEF_ROWS        = 256;
  localparam int DEF_SLOTS       = 16;
  localparam int DEF_COLUMN_BITS = 16;

  typedef logic [STATUS_W-1:0] write_status_t;

  localparam write_status_t WS_REPLACED = 2'd0;
  localparam write_status_t WS_INSERTED = 2'd1;
  localparam write_status_t WS_FULL     = 2'd2;

  // per-cycle command shared by every cell of the row
  typedef struct packed {
    logic load;
    logic upd_replace;
    logic upd_insert;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/sri_chan_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sri_in_if;
  import sri_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ROW_IDX_W-1:0] row_index;
  logic [COL_IDX_W-1:0] column_index;
  logic [VALUE_W-1:0]   entry_value;

  modport source (output valid, output row_index, output column_index,
                  output entry_value, input ready);
  modport sink   (input valid, input row_index, input column_index,
                  input entry_value, output ready);
endinterface

interface sri_out_if;
  import sri_pkg::*;

  logic                 valid;
  logic                 ready;
  write_status_t        write_status;
  logic [OUT_POS_W-1:0] slot_position;
  logic [OUT_POS_W-1:0] row_fill;

  modport source (output valid, output write_status, output slot_position,
                  output row_fill, input ready);
  modport sink   (input valid, input write_status, input slot_position,
                  input row_fill, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sparse_row_sorted_insert.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sparse matrix row store with sorted insertion of (column, value) entries.
// Input channel in_ch: one beat per write (row_index, column_index,
// entry_value). Output channel out_ch: one beat per write with write_status
// (replaced, inserted or row full), slot_position and the new row_fill.
// A whole row lives in one wide memory word together with its fill count.
// An accepted write reads its row, loads it into a chain of SLOTS cells,
// lets every cell compare against the column and, on an insert, shift from
// its left neighbour in one step, then writes the row back and offers the result.
// A write passes through the load, update and write-back steps and is done
// before the next is taken; the next beat is taken the cycle after the result is
// registered. The output register holds one result; while it is still held
// by a stalled receiver, the next write waits in its write-back step.
// After reset a clearing pass zeroes every row's fill count;
// no input beat is taken during it.

module sparse_row_sorted_insert #(
  parameter int ROWS        = sri_pkg::DEF_ROWS,
  parameter int SLOTS       = sri_pkg::DEF_SLOTS,
  parameter int COLUMN_BITS = sri_pkg::DEF_COLUMN_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sri_in_if.sink    in_ch,
  sri_out_if.source out_ch
);
  import sri_pkg::*;

  localparam int AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FILL_W = $clog2(SLOTS + 1);
  localparam int CELL_W = COLUMN_BITS + VALUE_W;
  localparam int WORD_W = SLOTS * CELL_W + FILL_W;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;

  logic [2:0]             state_r;
  logic [AW-1:0]          clr_r;
  logic [AW-1:0]          row_r;
  logic [COLUMN_BITS-1:0] key_col_r;
  logic [VALUE_W-1:0]     key_val_r;
  logic [FILL_W-1:0]      fill_r;
  write_status_t          res_status_r;
  logic [FILL_W-1:0]      res_pos_r;
  logic [FILL_W-1:0]      res_fill_r;
  logic                   out_valid_r;
  write_status_t          out_status_r;
  logic [OUT_POS_W-1:0]   out_pos_r;
  logic [OUT_POS_W-1:0]   out_fill_r;

  logic                   accept;
  logic                   push;
  logic [AW-1:0]          row_in;
  logic [COLUMN_BITS-1:0] col_in;
  logic [31:0]            col_wide;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WORD_W-1:0]      ram_wdata;
  logic [WORD_W-1:0]      ram_rdata;

  cell_ctl_t              ctl;
  logic [SLOTS-1:0]       c_lt;
  logic [SLOTS-1:0]       c_match;
  logic [SLOTS-1:0]       c_vld;
  logic [COLUMN_BITS-1:0] c_col [SLOTS];
  logic [VALUE_W-1:0]     c_val [SLOTS];

  logic                   match_any;
  logic                   full;
  logic [FILL_W-1:0]      pos_c;
  write_status_t          status_c;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign push         = (state_r == ST_WB) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.write_status  = out_status_r;
  assign out_ch.slot_position = out_pos_r;
  assign out_ch.row_fill      = out_fill_r;

  // row index reduced modulo ROWS by conditional subtraction
  always_comb begin
    logic [31:0] r;
    r = 32'(in_ch.row_index);
    for (int k = ROW_IDX_W - 1; k >= 0; k--) begin
      if (r >= (32'(ROWS) << k)) begin
        r = r - (32'(ROWS) << k);
      end
    end
    row_in = r[AW-1:0];
  end

  assign col_wide = 32'(in_ch.column_index);
  assign col_in   = col_wide[COLUMN_BITS-1:0];

  sri_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS),
    .AW    (AW)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (row_in),
    .rdata (ram_rdata)
  );

  assign ram_we    = (state_r == ST_CLR) || push;
  assign ram_waddr = (state_r == ST_CLR) ? clr_r : row_r;

  always_comb begin
    ram_wdata = '0;
    if (state_r != ST_CLR) begin
      for (int i = 0; i < SLOTS; i++) begin
        ram_wdata[i*CELL_W +: CELL_W] = {c_col[i], c_val[i]};
      end
      ram_wdata[SLOTS*CELL_W +: FILL_W] = res_fill_r;
    end
  end

  // the cell chain
  assign full      = (fill_r == FILL_W'(SLOTS));
  assign match_any = |c_match;

  always_comb begin
    ctl.load        = (state_r == ST_LOAD);
    ctl.upd_replace = (state_r == ST_UPD) && match_any;
    ctl.upd_insert  = (state_r == ST_UPD) && !match_any && !full;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic                   p_lt;
    logic                   p_vld;
    logic [COLUMN_BITS-1:0] p_col;
    logic [VALUE_W-1:0]     p_val;

    if (i == 0) begin : g_head
      assign p_lt  = 1'b1;
      assign p_vld = 1'b0;
      assign p_col = '0;
      assign p_val = '0;
    end else begin : g_link
      assign p_lt  = c_lt[i-1];
      assign p_vld = c_vld[i-1];
      assign p_col = c_col[i-1];
      assign p_val = c_val[i-1];
    end

    sri_cell #(
      .IDX         (i),
      .COLUMN_BITS (COLUMN_BITS),
      .FILL_W      (FILL_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .fill     (ram_rdata[SLOTS*CELL_W +: FILL_W]),
      .load_col (ram_rdata[i*CELL_W + VALUE_W +: COLUMN_BITS]),
      .load_val (ram_rdata[i*CELL_W +: VALUE_W]),
      .key_col  (key_col_r),
      .key_val  (key_val_r),
      .prev_lt  (p_lt),
      .prev_vld (p_vld),
      .prev_col (p_col),
      .prev_val (p_val),
      .lt       (c_lt[i]),
      .match    (c_match[i]),
      .vld      (c_vld[i]),
      .col      (c_col[i]),
      .val      (c_val[i])
    );
  end

  // lower bound: the one cell where the thermometer of lt drops, or SLOTS if every cell is below
  always_comb begin
    pos_c = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!c_lt[i] && ((i == 0) || c_lt[(i > 0) ? i - 1 : 0])) begin
        pos_c = pos_c | FILL_W'(i);
      end
    end
    if (c_lt[SLOTS-1]) begin
      pos_c = FILL_W'(SLOTS);
    end
  end

  always_comb begin
    if (match_any) begin
      status_c = WS_REPLACED;
    end else if (full) begin
      status_c = WS_FULL;
    end else begin
      status_c = WS_INSERTED;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(ROWS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: state_r <= ST_UPD;
        ST_UPD:  state_r <= ST_WB;
        ST_WB: begin
          if (push) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r     <= row_in;
      key_col_r <= col_in;
      key_val_r <= in_ch.entry_value;
    end
    if (state_r == ST_LOAD) begin
      fill_r <= ram_rdata[SLOTS*CELL_W +: FILL_W];
    end
    if (state_r == ST_UPD) begin
      res_status_r <= status_c;
      res_pos_r    <= pos_c;
      res_fill_r   <= (status_c == WS_INSERTED) ? fill_r + FILL_W'(1) : fill_r;
    end
    if (push) begin
      out_status_r <= res_status_r;
      out_pos_r    <= OUT_POS_W'(res_pos_r);
      out_fill_r   <= OUT_POS_W'(res_fill_r);
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_LOAD))
    else $error("accepted beat did not start a row load");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (fill_r <= FILL_W'(SLOTS)))
    else $error("row fill count beyond slot count");

  a_pos_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) && (res_status_r != WS_FULL) |-> (res_pos_r < res_fill_r))
    else $error("slot position outside the filled part of the row");

  a_push_clears_wb: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r && (state_r == ST_IDLE))
    else $error("result not registered after write-back");
`endif

endmodule

`default_nettype wire

/* hw/rtl/sri_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module sri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sri_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module sri_cell #(
  parameter int IDX         = 0,
  parameter int COLUMN_BITS = 16,
  parameter int FILL_W      = 5
) (
  input  wire logic                   clk,
  input  wire sri_pkg::cell_ctl_t     ctl,
  input  wire logic [FILL_W-1:0]      fill,
  input  wire logic [COLUMN_BITS-1:0] load_col,
  input  wire logic [63:0]            load_val,
  input  wire logic [COLUMN_BITS-1:0] key_col,
  input  wire logic [63:0]            key_val,
  input  wire logic                   prev_lt,
  input  wire logic                   prev_vld,
  input  wire logic [COLUMN_BITS-1:0] prev_col,
  input  wire logic [63:0]            prev_val,
  output logic                        lt,
  output logic                        match,
  output logic                        vld,
  output logic [COLUMN_BITS-1:0]      col,
  output logic [63:0]                 val
);
  import sri_pkg::*;

  logic                   vld_r;
  logic [COLUMN_BITS-1:0] col_r;
  logic [63:0]            val_r;

  // stored column below the key: the row is sorted, so lt forms a thermometer
  assign lt    = vld_r && (col_r < key_col);
  assign match = vld_r && (col_r == key_col);
  assign vld   = vld_r;
  assign col   = col_r;
  assign val   = val_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      col_r <= load_col;
      val_r <= load_val;
      vld_r <= (fill > FILL_W'(IDX));
    end else if (ctl.upd_replace) begin
      if (match) begin
        val_r <= key_val;
      end
    end else if (ctl.upd_insert) begin
      if (!lt) begin
        if (prev_lt) begin
          // first cell at or past the key takes the new entry
          col_r <= key_col;
          val_r <= key_val;
          vld_r <= 1'b1;
        end else begin
          col_r <= prev_col;
          val_r <= prev_val;
          vld_r <= prev_vld;
        end
      end
    end
  end

endmodule

`default_nettype wire
